FILE: rtl/host_coprocessor_mailbox_top_macros.svh
// Assertion macros shared by the mailbox RTL.
`ifndef HOST_COPROCESSOR_MAILBOX_TOP_MACROS_SVH
`define HOST_COPROCESSOR_MAILBOX_TOP_MACROS_SVH

// Checked on every rising edge of clk_i once reset is released.
`define HCM_ASSERT(label, prop, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Checked on every rising edge of clk_i, reset included.
`define HCM_ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk_i) prop) else $error(msg);

`endif

FILE: rtl/hcm_pkg.sv
// ----------------------------------------------------------------------------
// hcm_pkg
// Types, codes and constants of the host/coprocessor mailbox.
// ----------------------------------------------------------------------------
`default_nettype none

package hcm_pkg;

  localparam int DefLatchBytes = 2;

  // access codes
  typedef enum logic [2:0] {
    FUNC_HOST_RD = 3'd0,
    FUNC_HOST_WR = 3'd1,
    FUNC_TOP_RD  = 3'd2,
    FUNC_TOP_WR  = 3'd3,
    FUNC_ICU_RD  = 3'd4,
    FUNC_ICU_WR  = 3'd5
  } func_e;

  // host port select, address bits 2:1
  localparam logic [1:0] PORT_DATA    = 2'd0;
  localparam logic [1:0] PORT_STATUS  = 2'd1;
  localparam logic [1:0] PORT_BELL    = 2'd2;
  localparam logic [1:0] PORT_SERVICE = 2'd3;

  // interrupt controller register numbers (byte offset >> 2)
  localparam logic [18:0] REG_PORT_DATA = 19'd19;
  localparam logic [18:0] REG_SWAP      = 19'd20;
  localparam logic [18:0] REG_PORT_DIR  = 19'd21;

  localparam logic [7:0] BYTE_IDLE     = 8'hff;
  localparam logic [7:0] BYTE_BUSY     = 8'hfe;
  localparam logic [7:0] PIN_HOST_FULL = 8'h10;
  localparam int         G1_BIT        = 1;

  typedef struct packed {
    logic push;
    logic pop;
    logic refill;
    logic drop;
    logic flush;
  } latch_cmd_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       wait_res;
    logic       service_irq;
    logic       cpu_reset;
    logic       doorbell;
    logic       rom_mapped;
    logic       swap_commit;
    logic       icu_forward;
  } result_t;

endpackage

`default_nettype wire

FILE: rtl/host_coprocessor_mailbox_top.sv
// ----------------------------------------------------------------------------
// host_coprocessor_mailbox_top
// Host/coprocessor mailbox: byte latches both ways, service request, latched
// software reset, doorbell, G1 port shadows and ROM-swap staging.
// ----------------------------------------------------------------------------
//
//   channel | signals                                   | direction
//   --------+-------------------------------------------+----------
//   in      | in_valid_i, in_stall_o, func_i, address_i, | into block
//           | write_data_i                              |
//   out     | out_valid_o, out_stall_i, read_data_o ...  | out of block
//
// One access per cycle while the input is not stalled; the access sits in the
// input register after the edge that takes it, and its result then moves into
// the result register, or into the skid entry while the head is held.
// Reset restores all flags and empties both latches at once; no clearing pass.
// A two-entry result queue (result register plus skid) absorbs output stalls;
// the input stalls only while the skid entry and the input register are held.
`default_nettype none

`include "host_coprocessor_mailbox_top_macros.svh"

module host_coprocessor_mailbox_top
  import hcm_pkg::*;
#(
  parameter int LATCH_BYTES = DefLatchBytes
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        in_valid_i,
  output logic             in_stall_o,
  input  wire logic [2:0]  func_i,
  input  wire logic [20:0] address_i,
  input  wire logic [7:0]  write_data_i,
  output logic             out_valid_o,
  input  wire logic        out_stall_i,
  output logic [7:0]       read_data_o,
  output logic             wait_res_o,
  output logic             service_irq_o,
  output logic             cpu_reset_o,
  output logic             doorbell_o,
  output logic             rom_mapped_o,
  output logic             swap_commit_o,
  output logic             icu_forward_o
);

  // input register
  logic        s1_valid_q;
  logic [2:0]  s1_func_q;
  logic [20:0] s1_addr_q;
  logic [7:0]  s1_data_q;
  logic        s1_adv, in_accept;

  // result queue
  logic    head_valid_q, skid_valid_q;
  result_t head_q, skid_q, res;
  logic    pop;

  // mailbox state
  logic       rpo_q, rpo_d, wpo_q, wpo_d;
  logic       reset_q, reset_d, svc_q, svc_d;
  logic       swap_q, swap_d, staged_q, staged_d;
  logic [7:0] dir_q, dir_d, pdata_q, pdata_d, even_q, even_d;

  latch_cmd_t th_cmd, tc_cmd, th_cmd_g, tc_cmd_g;
  logic [7:0] th_front, tc_front, th_wdata;
  logic       th_empty, th_full, tc_empty, tc_full;

  logic        odd;
  logic [18:0] reg_no;
  logic [7:0]  pins;

  assign in_stall_o = s1_valid_q && skid_valid_q;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign s1_adv     = s1_valid_q && !skid_valid_q;
  assign pop        = head_valid_q && !out_stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= in_accept || (s1_valid_q && !s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      s1_func_q <= func_i;
      s1_addr_q <= address_i;
      s1_data_q <= write_data_i;
    end
  end

  // decode one access
  assign odd    = s1_addr_q[0];
  assign reg_no = s1_addr_q[20:2];

  always_comb begin
    res          = '0;
    res.read_data = BYTE_IDLE;
    th_cmd   = '0;
    tc_cmd   = '0;
    th_wdata = s1_data_q;
    rpo_d    = rpo_q;
    wpo_d    = wpo_q;
    reset_d  = reset_q;
    svc_d    = svc_q;
    swap_d   = swap_q;
    staged_d = staged_q;
    dir_d    = dir_q;
    pdata_d  = pdata_q;
    even_d   = even_q;
    pins     = th_empty ? (BYTE_IDLE & ~PIN_HOST_FULL) : BYTE_IDLE;

    unique case (s1_func_q)
      FUNC_HOST_RD: begin
        unique case (s1_addr_q[2:1])
          PORT_DATA: begin
            if (th_empty) begin
              // give the even byte back so the whole word goes again
              if (odd && rpo_q) begin
                th_cmd.refill = 1'b1;
                th_wdata      = even_q;
              end
              rpo_d        = 1'b0;
              res.wait_res = 1'b1;
            end else begin
              res.read_data = th_front;
              th_cmd.pop    = 1'b1;
              even_d        = th_front;
              rpo_d         = !odd;
            end
          end
          PORT_STATUS:  res.read_data = (th_empty && tc_empty) ? BYTE_IDLE : BYTE_BUSY;
          PORT_SERVICE: res.read_data = svc_q ? BYTE_BUSY : BYTE_IDLE;
          default: ;
        endcase
      end
      FUNC_HOST_WR: begin
        unique case (s1_addr_q[2:1])
          PORT_DATA: begin
            if (tc_full) begin
              // drop the even byte of a retried word
              if (odd && wpo_q) begin
                tc_cmd.drop = 1'b1;
                wpo_d       = 1'b0;
              end
              res.wait_res = 1'b1;
            end else begin
              tc_cmd.push = 1'b1;
              wpo_d       = !odd;
            end
          end
          PORT_STATUS: begin
            reset_d      = 1'b1;
            swap_d       = 1'b1;
            th_cmd.flush = 1'b1;
            tc_cmd.flush = 1'b1;
            rpo_d        = 1'b0;
            wpo_d        = 1'b0;
            svc_d        = 1'b0;
          end
          PORT_BELL: begin
            reset_d      = 1'b0;
            res.doorbell = 1'b1;
          end
          default: svc_d = 1'b0;
        endcase
      end
      FUNC_TOP_RD: begin
        if (!s1_addr_q[9]) begin
          if (s1_addr_q[8]) begin
            svc_d = 1'b1;
          end else if (tc_empty) begin
            res.wait_res = 1'b1;
          end else begin
            res.read_data = tc_front;
            tc_cmd.pop    = 1'b1;
          end
        end
      end
      FUNC_TOP_WR: begin
        if (s1_addr_q[9:8] == 2'b00) begin
          if (th_full) begin
            res.wait_res = 1'b1;
          end else begin
            th_cmd.push = 1'b1;
          end
        end
      end
      FUNC_ICU_RD: begin
        if (reg_no == REG_PORT_DATA) begin
          res.read_data = (pdata_q & ~dir_q) | (pins & dir_q);
        end else begin
          res.icu_forward = 1'b1;
        end
      end
      FUNC_ICU_WR: begin
        if (reg_no == REG_PORT_DIR) begin
          dir_d = s1_data_q;
        end
        if (reg_no == REG_PORT_DATA) begin
          pdata_d = s1_data_q;
          if (!dir_q[G1_BIT] && !s1_data_q[G1_BIT] && swap_q) begin
            staged_d = 1'b1;
          end
        end
        if (reg_no == REG_SWAP && staged_q) begin
          staged_d        = 1'b0;
          swap_d          = 1'b0;
          res.swap_commit = 1'b1;
        end
        res.icu_forward = 1'b1;
      end
      default: ;
    endcase

    res.service_irq = svc_d;
    res.cpu_reset   = reset_d;
    res.rom_mapped  = swap_d;
  end

  assign th_cmd_g = s1_adv ? th_cmd : '0;
  assign tc_cmd_g = s1_adv ? tc_cmd : '0;

  hcm_latch #(
    .Depth(LATCH_BYTES)
  ) u_to_host (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (th_cmd_g),
    .data_i  (th_wdata),
    .front_o (th_front),
    .empty_o (th_empty),
    .full_o  (th_full)
  );

  hcm_latch #(
    .Depth(LATCH_BYTES)
  ) u_to_coproc (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .cmd_i   (tc_cmd_g),
    .data_i  (s1_data_q),
    .front_o (tc_front),
    .empty_o (tc_empty),
    .full_o  (tc_full)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rpo_q    <= 1'b0;
      wpo_q    <= 1'b0;
      reset_q  <= 1'b0;
      svc_q    <= 1'b0;
      swap_q   <= 1'b1;
      staged_q <= 1'b0;
      dir_q    <= 8'hff;
      pdata_q  <= 8'hff;
      even_q   <= 8'h00;
    end else if (s1_adv) begin
      rpo_q    <= rpo_d;
      wpo_q    <= wpo_d;
      reset_q  <= reset_d;
      svc_q    <= svc_d;
      swap_q   <= swap_d;
      staged_q <= staged_d;
      dir_q    <= dir_d;
      pdata_q  <= pdata_d;
      even_q   <= even_d;
    end
  end

  // result queue: head register, skid behind it
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_valid_q <= 1'b0;
      skid_valid_q <= 1'b0;
    end else begin
      if (pop && skid_valid_q) begin
        skid_valid_q <= 1'b0;
      end else if (!pop && head_valid_q && s1_adv) begin
        skid_valid_q <= 1'b1;
      end
      if (pop || !head_valid_q) begin
        head_valid_q <= skid_valid_q || s1_adv;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop || !head_valid_q) begin
      head_q <= skid_valid_q ? skid_q : res;
    end
    if (!pop && head_valid_q && s1_adv) begin
      skid_q <= res;
    end
  end

  assign out_valid_o   = head_valid_q;
  assign read_data_o   = head_q.read_data;
  assign wait_res_o    = head_q.wait_res;
  assign service_irq_o = head_q.service_irq;
  assign cpu_reset_o   = head_q.cpu_reset;
  assign doorbell_o    = head_q.doorbell;
  assign rom_mapped_o  = head_q.rom_mapped;
  assign swap_commit_o = head_q.swap_commit;
  assign icu_forward_o = head_q.icu_forward;

  `HCM_ASSERT_ALWAYS(a_skid_behind_head, skid_valid_q |-> head_valid_q,
                     "skid entry held without a head entry")
  `HCM_ASSERT(a_wait_reads_idle, head_valid_q && head_q.wait_res |-> head_q.read_data == BYTE_IDLE,
              "wait result with read data")
  `HCM_ASSERT(a_commit_clears_rom, head_valid_q && head_q.swap_commit |-> !head_q.rom_mapped,
              "swap committed while ROM still mapped")

endmodule

`default_nettype wire

FILE: rtl/hcm_latch.sv
// ----------------------------------------------------------------------------
// hcm_latch
// Byte latch of Depth entries: push at the back, pop from the front, refill
// the front of an empty latch, drop the newest byte, flush.
// ----------------------------------------------------------------------------
`default_nettype none

`include "host_coprocessor_mailbox_top_macros.svh"

module hcm_latch
  import hcm_pkg::*;
#(
  parameter int Depth = DefLatchBytes
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire latch_cmd_t cmd_i,
  input  wire logic [7:0] data_i,
  output logic [7:0]      front_o,
  output logic            empty_o,
  output logic            full_o
);

  localparam int CntW = $clog2(Depth + 1);
  localparam int IdxW = $clog2(Depth);

  logic [7:0]      bytes_q [Depth];
  logic [CntW-1:0] count_q, count_d;

  assign front_o = bytes_q[0];
  assign empty_o = (count_q == '0);
  assign full_o  = (count_q == CntW'(Depth));

  always_comb begin
    count_d = count_q;
    priority if (cmd_i.flush) begin
      count_d = '0;
    end else if (cmd_i.push) begin
      count_d = count_q + CntW'(1);
    end else if (cmd_i.pop || cmd_i.drop) begin
      count_d = count_q - CntW'(1);
    end else if (cmd_i.refill) begin
      count_d = CntW'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push && !full_o) begin
      bytes_q[count_q[IdxW-1:0]] <= data_i;
    end else if (cmd_i.pop) begin
      // advance towards the front
      for (int i = 0; i < Depth - 1; i++) begin
        bytes_q[i] <= bytes_q[i+1];
      end
    end else if (cmd_i.refill) begin
      bytes_q[0] <= data_i;
    end
  end

  `HCM_ASSERT(a_count_in_range, count_q <= CntW'(Depth), "latch count beyond depth")
  `HCM_ASSERT(a_no_push_when_full, full_o && !cmd_i.flush |-> !cmd_i.push,
              "push into a full latch")
  `HCM_ASSERT(a_refill_only_empty, cmd_i.refill |-> empty_o, "refill of a non-empty latch")

endmodule

`default_nettype wire

FILE: verif/hcm_mailbox_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcm_mailbox_checker
// Watches both channels of the mailbox, keeps its own copy of the latches,
// flags, port shadows and ROM-swap stage, predicts the result of every
// accepted access and compares each returned result with the oldest one.
// ----------------------------------------------------------------------------

module hcm_mailbox_checker
  import hcm_pkg::*;
#(
  parameter int LATCH_BYTES = DefLatchBytes
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_stall_i,
  input  logic [2:0]        func_i,
  input  logic [20:0]       address_i,
  input  logic [7:0]        write_data_i,
  input  logic              out_valid_i,
  input  logic              out_stall_i,
  input  logic [7:0]        read_data_i,
  input  logic              wait_res_i,
  input  logic              service_irq_i,
  input  logic              cpu_reset_i,
  input  logic              doorbell_i,
  input  logic              rom_mapped_i,
  input  logic              swap_commit_i,
  input  logic              icu_forward_i,
  output int unsigned       mismatches_o,
  output int unsigned       pending_o
);

  localparam int TopBankBit    = 9;
  localparam int TopServiceBit = 8;

  // byte 0 of each latch is the oldest
  logic [LATCH_BYTES*8-1:0] coproc_bytes;
  logic [LATCH_BYTES*8-1:0] host_bytes;
  int unsigned              coproc_count;
  int unsigned              host_count;
  logic [7:0]               last_even_byte;
  logic                     read_pair_open;
  logic                     write_pair_open;
  logic                     reset_latched;
  logic                     service_flag;
  logic [7:0]               port_dir;
  logic [7:0]               port_data;
  logic                     rom_swap;
  logic                     swap_staged;

  result_t                  mailbox_results[$];
  result_t                  predicted;
  result_t                  observed;

  task automatic predict_access(input logic [2:0] fn, input logic [20:0] addr,
                                input logic [7:0] data, output result_t res);
    logic        odd;
    logic [18:0] reg_no;
    logic [7:0]  pins;
    odd    = addr[0];
    reg_no = addr[20:2];
    res    = '0;
    res.read_data = BYTE_IDLE;
    case (fn)
      FUNC_HOST_RD: begin
        case (addr[2:1])
          PORT_DATA: begin
            if (host_count == 0) begin
              // retried odd byte: give the even byte back
              if (odd && read_pair_open) begin
                host_bytes[7:0] = last_even_byte;
                host_count = 1;
              end
              read_pair_open = 1'b0;
              res.wait_res = 1'b1;
            end else begin
              res.read_data  = host_bytes[7:0];
              host_bytes     = host_bytes >> 8;
              host_count--;
              last_even_byte = res.read_data;
              read_pair_open = !odd;
            end
          end
          PORT_STATUS: begin
            res.read_data = (host_count == 0 && coproc_count == 0) ? BYTE_IDLE : BYTE_BUSY;
          end
          PORT_SERVICE: res.read_data = service_flag ? BYTE_BUSY : BYTE_IDLE;
          default: ;
        endcase
      end
      FUNC_HOST_WR: begin
        case (addr[2:1])
          PORT_DATA: begin
            if (coproc_count >= LATCH_BYTES) begin
              // retried odd byte: drop the newest so the pair goes again
              if (odd && write_pair_open) begin
                coproc_count--;
                write_pair_open = 1'b0;
              end
              res.wait_res = 1'b1;
            end else begin
              coproc_bytes[coproc_count*8 +: 8] = data;
              coproc_count++;
              write_pair_open = !odd;
            end
          end
          PORT_STATUS: begin
            reset_latched   = 1'b1;
            rom_swap        = 1'b1;
            coproc_count    = 0;
            host_count      = 0;
            read_pair_open  = 1'b0;
            write_pair_open = 1'b0;
            service_flag    = 1'b0;
          end
          PORT_BELL: begin
            reset_latched = 1'b0;
            res.doorbell  = 1'b1;
          end
          default: service_flag = 1'b0;
        endcase
      end
      FUNC_TOP_RD: begin
        if (!addr[TopBankBit]) begin
          if (addr[TopServiceBit]) begin
            service_flag = 1'b1;
          end else if (coproc_count == 0) begin
            res.wait_res = 1'b1;
          end else begin
            res.read_data = coproc_bytes[7:0];
            coproc_bytes  = coproc_bytes >> 8;
            coproc_count--;
          end
        end
      end
      FUNC_TOP_WR: begin
        if (!addr[TopBankBit] && !addr[TopServiceBit]) begin
          if (host_count >= LATCH_BYTES) begin
            res.wait_res = 1'b1;
          end else begin
            host_bytes[host_count*8 +: 8] = data;
            host_count++;
          end
        end
      end
      FUNC_ICU_RD: begin
        if (reg_no == REG_PORT_DATA) begin
          pins = BYTE_IDLE;
          if (host_count == 0) pins = pins & ~PIN_HOST_FULL;
          res.read_data = (port_data & ~port_dir) | (pins & port_dir);
        end else begin
          res.icu_forward = 1'b1;
        end
      end
      FUNC_ICU_WR: begin
        if (reg_no == REG_PORT_DIR) port_dir = data;
        if (reg_no == REG_PORT_DATA) begin
          port_data = data;
          if (!port_dir[G1_BIT] && !data[G1_BIT] && rom_swap) swap_staged = 1'b1;
        end
        if (reg_no == REG_SWAP && swap_staged) begin
          swap_staged     = 1'b0;
          rom_swap        = 1'b0;
          res.swap_commit = 1'b1;
        end
        res.icu_forward = 1'b1;
      end
      default: ;
    endcase
    res.service_irq = service_flag;
    res.cpu_reset   = reset_latched;
    res.rom_mapped  = rom_swap;
  endtask

  task automatic check_field(input string name, input logic [7:0] want,
                             input logic [7:0] got);
    if (want !== got) begin
      $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
      mismatches_o++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      coproc_bytes    = '0;
      host_bytes      = '0;
      coproc_count    = 0;
      host_count      = 0;
      last_even_byte  = '0;
      read_pair_open  = 1'b0;
      write_pair_open = 1'b0;
      reset_latched   = 1'b0;
      service_flag    = 1'b0;
      port_dir        = 8'hff;
      port_data       = 8'hff;
      rom_swap        = 1'b1;
      swap_staged     = 1'b0;
      mailbox_results.delete();
      mismatches_o    = 0;
    end else begin
      if (in_valid_i && !in_stall_i) begin
        predict_access(func_i, address_i, write_data_i, predicted);
        mailbox_results.insert(mailbox_results.size(), predicted);
      end
      if (out_valid_i && !out_stall_i) begin
        observed = {read_data_i, wait_res_i, service_irq_i, cpu_reset_i, doorbell_i,
                    rom_mapped_i, swap_commit_i, icu_forward_i};
        if (mailbox_results.size() == 0) begin
          $display("%0t: result with no access pending: expected none, actual %0h",
                   $time, observed);
          mismatches_o++;
        end else begin
          // take the oldest prediction
          predicted = mailbox_results[0];
          mailbox_results.delete(0);
          check_field("read_data", predicted.read_data, observed.read_data);
          check_field("wait_res", 8'(predicted.wait_res), 8'(observed.wait_res));
          check_field("service_irq", 8'(predicted.service_irq), 8'(observed.service_irq));
          check_field("cpu_reset", 8'(predicted.cpu_reset), 8'(observed.cpu_reset));
          check_field("doorbell", 8'(predicted.doorbell), 8'(observed.doorbell));
          check_field("rom_mapped", 8'(predicted.rom_mapped), 8'(observed.rom_mapped));
          check_field("swap_commit", 8'(predicted.swap_commit), 8'(observed.swap_commit));
          check_field("icu_forward", 8'(predicted.icu_forward), 8'(observed.icu_forward));
        end
      end
    end
    pending_o = mailbox_results.size();
  end

endmodule

FILE: verif/tb_host_coprocessor_mailbox_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_host_coprocessor_mailbox_top
// Drives host, top-region and interrupt-controller accesses into the mailbox:
// a directed opening over the latch, retry, flag and ROM-swap cases, then
// random traffic in three idling phases. The checker predicts and compares.
// ----------------------------------------------------------------------------

module tb_host_coprocessor_mailbox_top;
  import hcm_pkg::*;

  localparam int CYCLE_LIMIT  = 200000;
  localparam int DRAIN_CYCLES = 16;
  localparam int PHASE_ITEMS  = 340;

  logic        clk;
  logic        rst_n        = 1'b0;
  logic        in_valid     = 1'b0;
  logic        in_stall;
  logic [2:0]  func         = '0;
  logic [20:0] address      = '0;
  logic [7:0]  write_data   = '0;
  logic        out_valid;
  logic        out_stall    = 1'b0;
  logic [7:0]  read_data;
  logic        wait_res;
  logic        service_irq;
  logic        cpu_reset;
  logic        doorbell;
  logic        rom_mapped;
  logic        swap_commit;
  logic        icu_forward;

  int unsigned mismatches;
  int unsigned pending;
  int unsigned send_idle_pct = 16;
  int unsigned stall_pct     = 64;
  int unsigned accesses_sent = 0;

  host_coprocessor_mailbox_top dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .func_i        (func),
    .address_i     (address),
    .write_data_i  (write_data),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_o   (read_data),
    .wait_res_o    (wait_res),
    .service_irq_o (service_irq),
    .cpu_reset_o   (cpu_reset),
    .doorbell_o    (doorbell),
    .rom_mapped_o  (rom_mapped),
    .swap_commit_o (swap_commit),
    .icu_forward_o (icu_forward)
  );

  hcm_mailbox_checker checker_i (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .in_valid_i    (in_valid),
    .in_stall_i    (in_stall),
    .func_i        (func),
    .address_i     (address),
    .write_data_i  (write_data),
    .out_valid_i   (out_valid),
    .out_stall_i   (out_stall),
    .read_data_i   (read_data),
    .wait_res_i    (wait_res),
    .service_irq_i (service_irq),
    .cpu_reset_i   (cpu_reset),
    .doorbell_i    (doorbell),
    .rom_mapped_i  (rom_mapped),
    .swap_commit_i (swap_commit),
    .icu_forward_i (icu_forward),
    .mismatches_o  (mismatches),
    .pending_o     (pending)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < stall_pct);

  // host decode ignores the upper bits, so scatter them now and then
  function automatic logic [20:0] host_addr(input logic [1:0] port, input logic odd);
    logic [17:0] upper;
    upper = ($urandom_range(3) == 0) ? 18'($urandom) : '0;
    return {upper, port, odd};
  endfunction

  function automatic logic [20:0] top_addr(input logic [1:0] bank);
    logic [20:0] addr;
    addr      = 21'($urandom);
    addr[9:8] = bank;
    return addr;
  endfunction

  function automatic logic [20:0] icu_addr(input logic [18:0] reg_no);
    return {reg_no, 2'($urandom)};
  endfunction

  task automatic send_access(input logic [2:0] fn, input logic [20:0] addr,
                             input logic [7:0] data);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid   <= 1'b1;
    func       <= fn;
    address    <= addr;
    write_data <= data;
    @(posedge clk);
    // hold the word until it is taken
    while (in_stall) @(posedge clk);
    accesses_sent++;
  endtask

  task automatic random_access();
    int unsigned pick;
    int unsigned sub;
    pick = $urandom_range(99);
    sub  = $urandom_range(4);
    if (pick < 22) begin
      send_access(FUNC_HOST_WR, host_addr(PORT_DATA, 1'b0), 8'($urandom));
      send_access(FUNC_HOST_WR, host_addr(PORT_DATA, 1'b1), 8'($urandom));
    end else if (pick < 44) begin
      send_access(FUNC_HOST_RD, host_addr(PORT_DATA, 1'b0), 8'($urandom));
      send_access(FUNC_HOST_RD, host_addr(PORT_DATA, 1'b1), 8'($urandom));
    end else if (pick < 58) begin
      send_access(FUNC_TOP_WR, top_addr(2'b00), 8'($urandom));
    end else if (pick < 72) begin
      send_access(FUNC_TOP_RD, top_addr(2'b00), 8'($urandom));
    end else if (pick < 76) begin
      send_access($urandom_range(1) ? FUNC_TOP_RD : FUNC_TOP_WR,
                  top_addr(2'($urandom_range(3, 1))), 8'($urandom));
    end else if (pick < 80) begin
      send_access($urandom_range(1) ? FUNC_HOST_RD : FUNC_HOST_WR,
                  host_addr(PORT_DATA, 1'($urandom)), 8'($urandom));
    end else if (pick < 83) begin
      send_access(FUNC_HOST_RD, host_addr(2'($urandom), 1'($urandom)), 8'($urandom));
    end else if (pick < 86) begin
      send_access(FUNC_HOST_WR, host_addr(PORT_SERVICE, 1'($urandom)), 8'($urandom));
    end else if (pick < 88) begin
      send_access(FUNC_HOST_WR, host_addr(PORT_BELL, 1'($urandom)), 8'($urandom));
    end else if (pick < 89) begin
      send_access(FUNC_HOST_WR, host_addr(PORT_STATUS, 1'($urandom)), 8'($urandom));
    end else if (pick < 97) begin
      case (sub)
        0: send_access(FUNC_ICU_WR, icu_addr(REG_PORT_DIR), 8'($urandom));
        1: send_access(FUNC_ICU_WR, icu_addr(REG_PORT_DATA), 8'($urandom));
        2: send_access(FUNC_ICU_WR, icu_addr(REG_SWAP), 8'($urandom));
        3: send_access(FUNC_ICU_RD, icu_addr(REG_PORT_DATA), 8'($urandom));
        default: send_access($urandom_range(1) ? FUNC_ICU_RD : FUNC_ICU_WR,
                             21'($urandom), 8'($urandom));
      endcase
    end else begin
      send_access(3'($urandom), 21'($urandom), 8'($urandom));
    end
  endtask

  task automatic random_phase(input int unsigned idle, input int unsigned stall,
                              input int unsigned count);
    int unsigned target;
    send_idle_pct = idle;
    stall_pct     = stall;
    target        = accesses_sent + count;
    while (accesses_sent < target) random_access();
  endtask

  initial begin
    repeat (CYCLE_LIMIT) @(posedge clk);
    $display("** host_coprocessor_mailbox_top: FAILED **");
    $finish;
  end

  initial begin
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // latch to the host: empty, fill, full, drain
    send_access(FUNC_HOST_RD, 21'h000000, 8'h00);
    send_access(FUNC_HOST_RD, 21'h000002, 8'h00);
    send_access(FUNC_TOP_WR, 21'h000000, 8'h00);
    send_access(FUNC_TOP_WR, 21'h1ffcff, 8'hff);
    send_access(FUNC_TOP_WR, 21'h000000, 8'h5a);
    send_access(FUNC_HOST_RD, 21'h000002, 8'h00);
    send_access(FUNC_HOST_RD, 21'h000000, 8'h00);
    send_access(FUNC_HOST_RD, 21'h000001, 8'h00);
    // odd byte retried on an empty latch gets the even byte back
    send_access(FUNC_TOP_WR, 21'h000000, 8'ha5);
    send_access(FUNC_HOST_RD, 21'h000000, 8'h00);
    send_access(FUNC_HOST_RD, 21'h000001, 8'h00);
    send_access(FUNC_HOST_RD, 21'h1ffff8, 8'h00);
    // odd byte retried on a full latch drops the newest
    send_access(FUNC_HOST_WR, 21'h000000, 8'h12);
    send_access(FUNC_HOST_WR, 21'h000000, 8'h34);
    send_access(FUNC_HOST_WR, 21'h1ffff9, 8'h56);
    send_access(FUNC_TOP_RD, 21'h000000, 8'h00);
    send_access(FUNC_TOP_RD, 21'h1ffcff, 8'h00);
    // service request raised from the top region, seen and cleared by the host
    send_access(FUNC_TOP_RD, 21'h000100, 8'h00);
    send_access(FUNC_HOST_RD, 21'h000006, 8'h00);
    send_access(FUNC_TOP_WR, 21'h1fffff, 8'hff);
    send_access(FUNC_HOST_WR, 21'h000007, 8'h00);
    // port shadows and ROM swap
    send_access(FUNC_ICU_RD, icu_addr(REG_PORT_DATA), 8'h00);
    send_access(FUNC_ICU_WR, icu_addr(REG_PORT_DIR), 8'h00);
    send_access(FUNC_ICU_WR, icu_addr(REG_PORT_DATA), 8'h00);
    send_access(FUNC_ICU_WR, icu_addr(REG_SWAP), 8'hff);
    send_access(FUNC_HOST_WR, 21'h000002, 8'h00);
    send_access(FUNC_HOST_WR, 21'h000004, 8'h00);
    send_access(FUNC_ICU_RD, 21'h1fffff, 8'h00);
    send_access(3'd6, 21'h1fffff, 8'hff);
    send_access(3'd7, 21'h000000, 8'h00);

    random_phase(16, 64, PHASE_ITEMS);
    random_phase(64, 16, PHASE_ITEMS);
    random_phase(0, 0, PHASE_ITEMS);
    in_valid <= 1'b0;

    while (pending != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatches == 0) begin
      $display("** host_coprocessor_mailbox_top: PASSED **");
    end else begin
      $display("** host_coprocessor_mailbox_top: FAILED **");
    end
    $finish;
  end

endmodule
